// File: src/ajwm_pkg.sv
// Shared constants, types and helper functions of the angle jitter window monitor.
package ajwm_pkg;

  localparam int WINDOW_DEPTH  = 25;
  localparam int CHANNEL_COUNT = 4;
  localparam int ANGLE_BITS    = 12;

  localparam int MAX_CHANNELS  = 4;
  localparam int IN_ANGLE_W    = 12;
  localparam int NOISE_W       = 12;
  localparam int COUNT_W       = 5;

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  typedef logic [ANGLE_BITS-1:0] angle_t;
  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Sequencer commands broadcast to every lane.
  typedef struct packed {
    logic start;
    ptr_t wr_addr;
    logic rd_en;
    ptr_t rd_addr;
    logic cmp_en;
    cnt_t cmp_idx;
  } ctl_t;

  // What one lane reports for its channel.
  typedef struct packed {
    logic [NOISE_W-1:0] noise;
    logic [COUNT_W-1:0] count;
  } lane_res_t;

  // Fit the raw input angle to ANGLE_BITS (zero-extend or truncate).
  function automatic angle_t fit_angle(input logic [IN_ANGLE_W-1:0] a);
    logic [ANGLE_BITS+IN_ANGLE_W-1:0] wide;
    wide = {{ANGLE_BITS{1'b0}}, a};
    return wide[ANGLE_BITS-1:0];
  endfunction

  // Circular distance min(d, 2^ANGLE_BITS - d), d = (a - b) mod 2^ANGLE_BITS.
  function automatic angle_t circ_dist(input angle_t a, input angle_t b);
    angle_t                d;
    logic [ANGLE_BITS:0]   e;
    d = a - b;
    e = {1'b1, {ANGLE_BITS{1'b0}}} - {1'b0, d};
    if ({1'b0, d} < e) begin
      return d;
    end
    return e[ANGLE_BITS-1:0];
  endfunction

  function automatic logic [NOISE_W-1:0] fit_noise(input angle_t n);
    logic [ANGLE_BITS+NOISE_W-1:0] wide;
    wide = {{NOISE_W{1'b0}}, n};
    return wide[NOISE_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] fit_count(input cnt_t c);
    logic [CNT_W+COUNT_W-1:0] wide;
    wide = {{COUNT_W{1'b0}}, c};
    return wide[COUNT_W-1:0];
  endfunction

endpackage

// File: src/angle_jitter_window_monitor.sv
// Top level of the angle jitter window monitor: input stage, lanes, sequencer and merged output.
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_stall   clear_counts, angle_a..d, healthy_a..d
//   out_      output     out_valid / out_stall noise_a..d, count_a..d
//
// At a scan's transfer the new angles are written; then each lane reads the
// WINDOW_DEPTH - 1 older entries through its single memory read port, one per cycle,
// compares each against the new angle, and after the last compare the result is loaded
// into the output register once that register is free. The next scan can transfer only
// after that load, so the block never takes a new scan while one is in flight.
// All lanes walk the window together; entries beyond a lane's count are ignored.
// in_stall stays high from a transfer until the result has moved into the output
// register, which keeps it while out_stall is high. Reset (rst_n low, synchronous)
// zeroes all sample counts and the shared ring cursor; ring contents are not cleared.
module angle_jitter_window_monitor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_clear_counts,
  input  logic [ajwm_pkg::IN_ANGLE_W-1:0] in_angle_a,
  input  logic                           in_healthy_a,
  input  logic [ajwm_pkg::IN_ANGLE_W-1:0] in_angle_b,
  input  logic                           in_healthy_b,
  input  logic [ajwm_pkg::IN_ANGLE_W-1:0] in_angle_c,
  input  logic                           in_healthy_c,
  input  logic [ajwm_pkg::IN_ANGLE_W-1:0] in_angle_d,
  input  logic                           in_healthy_d,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ajwm_pkg::NOISE_W-1:0]   out_noise_a,
  output logic [ajwm_pkg::COUNT_W-1:0]   out_count_a,
  output logic [ajwm_pkg::NOISE_W-1:0]   out_noise_b,
  output logic [ajwm_pkg::COUNT_W-1:0]   out_count_b,
  output logic [ajwm_pkg::NOISE_W-1:0]   out_noise_c,
  output logic [ajwm_pkg::COUNT_W-1:0]   out_count_c,
  output logic [ajwm_pkg::NOISE_W-1:0]   out_noise_d,
  output logic [ajwm_pkg::COUNT_W-1:0]   out_count_d
);
  import ajwm_pkg::*;

  ctl_t      ctl;
  logic      busy;
  logic      done;
  logic      in_xfer;
  logic      out_free;
  logic      out_valid_r, out_valid_nxt;
  lane_res_t out_res_r [MAX_CHANNELS];
  lane_res_t lane_res  [MAX_CHANNELS];
  logic [IN_ANGLE_W-1:0] angle_in   [MAX_CHANNELS];
  logic                  healthy_in [MAX_CHANNELS];

  // The block takes a new scan only when nothing is in flight.
  assign in_stall = busy;
  assign in_xfer  = in_valid && !busy;

  // The output register can take a result when it is empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  assign angle_in[0]   = in_angle_a;
  assign angle_in[1]   = in_angle_b;
  assign angle_in[2]   = in_angle_c;
  assign angle_in[3]   = in_angle_d;
  assign healthy_in[0] = in_healthy_a;
  assign healthy_in[1] = in_healthy_b;
  assign healthy_in[2] = in_healthy_c;
  assign healthy_in[3] = in_healthy_d;

  ajwm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_xfer),
    .out_free (out_free),
    .ctl      (ctl),
    .busy     (busy),
    .done     (done)
  );

  // One lane per configured channel; channels beyond that report zero noise and count.
  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
    if (g < CHANNEL_COUNT) begin : g_on
      ajwm_lane u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .clear   (in_clear_counts),
        .angle   (angle_in[g]),
        .healthy (healthy_in[g]),
        .res     (lane_res[g])
      );
    end else begin : g_off
      assign lane_res[g] = '0;
    end
  end

  // Merge stage: every lane's finding lands in the output register in the same cycle.
  assign out_valid_nxt = done || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        out_res_r[i] <= lane_res[i];
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_noise_a = out_res_r[0].noise;
  assign out_count_a = out_res_r[0].count;
  assign out_noise_b = out_res_r[1].noise;
  assign out_count_b = out_res_r[1].count;
  assign out_noise_c = out_res_r[2].noise;
  assign out_count_c = out_res_r[2].count;
  assign out_noise_d = out_res_r[3].noise;
  assign out_count_d = out_res_r[3].count;

endmodule

// File: src/ajwm_lane.sv
// One channel lane: window ring memory, sample count and running maximum of the spread.
module ajwm_lane (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ajwm_pkg::ctl_t                     ctl,
  input  logic                               clear,
  input  logic [ajwm_pkg::IN_ANGLE_W-1:0]    angle,
  input  logic                               healthy,
  output ajwm_pkg::lane_res_t                res
);
  import ajwm_pkg::*;

  angle_t ring_mem [WINDOW_DEPTH];
  angle_t rd_data_r;
  angle_t ang_r;
  angle_t noise_r;
  angle_t noise_nxt;
  angle_t arc_d;
  cnt_t   cnt_r;
  cnt_t   cnt_nxt;
  cnt_t   cnt_base;

  always_ff @(posedge clk) begin
    if (ctl.start && healthy) begin
      ring_mem[ctl.wr_addr] <= fit_angle(angle);
    end
    if (ctl.rd_en) begin
      rd_data_r <= ring_mem[ctl.rd_addr];
    end
  end

  always_comb begin
    cnt_base = clear ? '0 : cnt_r;
    cnt_nxt  = cnt_r;
    if (ctl.start) begin
      if (!healthy) begin
        cnt_nxt = '0;
      end else if (cnt_base == CNT_W'(WINDOW_DEPTH)) begin
        cnt_nxt = cnt_base;
      end else begin
        cnt_nxt = cnt_base + 1'b1;
      end
    end
  end

  // Only entries inside the current window take part in the maximum.
  assign arc_d = circ_dist(ang_r, rd_data_r);

  always_comb begin
    noise_nxt = noise_r;
    if (ctl.start) begin
      noise_nxt = '0;
    end else if (ctl.cmp_en && (ctl.cmp_idx < cnt_r) && (arc_d > noise_r)) begin
      noise_nxt = arc_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    noise_r <= noise_nxt;
    if (ctl.start) begin
      ang_r <= fit_angle(angle);
    end
  end

  assign res.noise = fit_noise(noise_r);
  assign res.count = fit_count(cnt_r);

endmodule

// File: src/ajwm_seq.sv
// Window walk sequencer: shared ring cursor, read index walk and lane command generation.
module ajwm_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           out_free,
  output ajwm_pkg::ctl_t ctl,
  output logic           busy,
  output logic           done
);
  import ajwm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;
  localparam int SUM_W = CNT_W + 1;

  logic [1:0]   state_r, state_nxt;
  ptr_t         cursor_r, cursor_nxt;
  ptr_t         item_cur_r;
  cnt_t         idx_r, idx_nxt;
  logic         cmp_en_r;
  cnt_t         cmp_idx_r;
  logic         rd_en;
  logic         walk_end;
  logic [SUM_W-1:0] addr_sum;
  logic [SUM_W-1:0] addr_wrap;

  assign walk_end = (idx_r == CNT_W'(WINDOW_DEPTH));
  assign rd_en    = (state_r == S_RUN) && !walk_end;

  // Ring address of the entry idx_r scans back from the item's cursor.
  always_comb begin
    addr_sum = SUM_W'(item_cur_r) + SUM_W'(WINDOW_DEPTH) - SUM_W'(idx_r);
    if (addr_sum >= SUM_W'(WINDOW_DEPTH)) begin
      addr_wrap = addr_sum - SUM_W'(WINDOW_DEPTH);
    end else begin
      addr_wrap = addr_sum;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cursor_nxt = cursor_r;
    done       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt  = S_RUN;
          idx_nxt    = CNT_W'(1);
          cursor_nxt = (cursor_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : cursor_r + 1'b1;
        end
      end
      S_RUN: begin
        if (!walk_end) begin
          idx_nxt = idx_r + 1'b1;
        end else if (cmp_en_r) begin
          // The compare of the oldest entry lands in the lanes at this edge.
          state_nxt = S_RUN;
        end else if (out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cursor_r <= '0;
      idx_r    <= '0;
      cmp_en_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      idx_r    <= idx_nxt;
      cmp_en_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= idx_r;
    if (start && (state_r == S_IDLE)) begin
      item_cur_r <= cursor_r;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign ctl.start   = start && (state_r == S_IDLE);
  assign ctl.wr_addr = cursor_r;
  assign ctl.rd_en   = rd_en;
  assign ctl.rd_addr = addr_wrap[PTR_W-1:0];
  assign ctl.cmp_en  = cmp_en_r;
  assign ctl.cmp_idx = cmp_idx_r;

endmodule

// File: bench/tb.sv
// Self-checking testbench for the angle jitter window monitor.
`timescale 1ns / 1ps

module tb;
  import ajwm_pkg::*;

  // Run shape. The three handshake idle profiles each cover one stretch of
  // accepted scans; the long output hold-off starts once the third stretch
  // is well under way, where neither side idles at random.
  localparam int DIRECTED_SCANS = 18;
  localparam int RANDOM_SCANS   = 1132;
  localparam int PROFILE_LEN    = 400;
  localparam int HOLD_START     = 900;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = WINDOW_DEPTH + 8;
  localparam int PRINT_CAP      = 40;
  localparam int ANGLE_TOP      = (1 << IN_ANGLE_W) - 1;

  // Idle rates, in percent, for the first two profiles.
  localparam int IDLE_LOW_PCT  = 35;
  localparam int IDLE_HIGH_PCT = 50;

  // One scan as it crosses the input channel; index 0 is channel a.
  typedef struct packed {
    logic                                  clear;
    logic [MAX_CHANNELS-1:0][IN_ANGLE_W-1:0] angle;
    logic [MAX_CHANNELS-1:0]               healthy;
  } scan_t;

  // One result as it crosses the output channel.
  typedef struct packed {
    logic [MAX_CHANNELS-1:0][NOISE_W-1:0] noise;
    logic [MAX_CHANNELS-1:0][COUNT_W-1:0] count;
  } jitter_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic                  in_clear_counts = 1'b0;
  logic [IN_ANGLE_W-1:0] in_angle_a      = '0;
  logic                  in_healthy_a    = 1'b0;
  logic [IN_ANGLE_W-1:0] in_angle_b      = '0;
  logic                  in_healthy_b    = 1'b0;
  logic [IN_ANGLE_W-1:0] in_angle_c      = '0;
  logic                  in_healthy_c    = 1'b0;
  logic [IN_ANGLE_W-1:0] in_angle_d      = '0;
  logic                  in_healthy_d    = 1'b0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic [NOISE_W-1:0]    out_noise_a;
  logic [COUNT_W-1:0]    out_count_a;
  logic [NOISE_W-1:0]    out_noise_b;
  logic [COUNT_W-1:0]    out_count_b;
  logic [NOISE_W-1:0]    out_noise_c;
  logic [COUNT_W-1:0]    out_count_c;
  logic [NOISE_W-1:0]    out_noise_d;
  logic [COUNT_W-1:0]    out_count_d;

  angle_jitter_window_monitor u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_clear_counts (in_clear_counts),
    .in_angle_a      (in_angle_a),
    .in_healthy_a    (in_healthy_a),
    .in_angle_b      (in_angle_b),
    .in_healthy_b    (in_healthy_b),
    .in_angle_c      (in_angle_c),
    .in_healthy_c    (in_healthy_c),
    .in_angle_d      (in_angle_d),
    .in_healthy_d    (in_healthy_d),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_noise_a     (out_noise_a),
    .out_count_a     (out_count_a),
    .out_noise_b     (out_noise_b),
    .out_count_b     (out_count_b),
    .out_noise_c     (out_noise_c),
    .out_count_c     (out_count_c),
    .out_noise_d     (out_noise_d),
    .out_count_d     (out_count_d)
  );

  // Scans waiting to be offered, and results the window model says must come.
  scan_t   scan_backlog[$];
  jitter_t jitter_due[$];
  scan_t   offered_scan;
  int      total_scans;

  // scans_sent only changes through a nonblocking assignment, so all
  // processes woken together by the clock read the same value.
  int scans_sent   = 0;
  int results_seen = 0;
  int full_windows = 0;
  int mismatches   = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  string lane_tag [MAX_CHANNELS] = '{"a", "b", "c", "d"};

  // ---------------------------------------------------------------------
  // Window model: its own ring per channel, the shared write slot and the
  // number of consecutive healthy samples each channel holds.
  // ---------------------------------------------------------------------
  angle_t angle_hist [MAX_CHANNELS][WINDOW_DEPTH];
  int     window_fill [MAX_CHANNELS] = '{default: 0};
  int     ring_pos = 0;

  // Shorter of the two ways round the circle between two angles.
  function automatic angle_t arc_gap(input angle_t x, input angle_t y);
    angle_t fwd;
    angle_t rev;
    fwd = x - y;
    rev = y - x;
    // Half a turn apart both ways give the same value, which still fits.
    if (fwd == rev) begin
      return fwd;
    end
    return (fwd < rev) ? fwd : rev;
  endfunction

  // Applies one accepted scan to the model and returns the result it causes.
  function automatic jitter_t advance_window(input scan_t s);
    jitter_t r;
    angle_t  ang;
    angle_t  spread;
    angle_t  gap;
    int      slot;
    r = '0;
    if (s.clear) begin
      for (int ch = 0; ch < MAX_CHANNELS; ch++) window_fill[ch] = 0;
    end
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      // Lanes past the configured channel count stay at zero.
      if (ch < CHANNEL_COUNT) begin
        if (!s.healthy[ch]) begin
          window_fill[ch] = 0;
        end else begin
          ang = angle_t'(s.angle[ch]);
          angle_hist[ch][ring_pos] = ang;
          if (window_fill[ch] < WINDOW_DEPTH) window_fill[ch]++;
          // Walk back from the newest entry over the filled part only, so
          // a slot never written since reset is never looked at.
          spread = '0;
          for (int k = 0; k < window_fill[ch]; k++) begin
            slot = (ring_pos - k + WINDOW_DEPTH) % WINDOW_DEPTH;
            gap  = arc_gap(ang, angle_hist[ch][slot]);
            if (gap > spread) spread = gap;
          end
          r.noise[ch] = NOISE_W'(spread);
          r.count[ch] = COUNT_W'(window_fill[ch]);
        end
      end
    end
    ring_pos = (ring_pos + 1) % WINDOW_DEPTH;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  // Queues one directed scan; bit 0 of the health mask belongs to channel a.
  task automatic push_scan(input bit clr, input int a, input int b, input int c,
                           input int d, input logic [3:0] ok_mask);
    scan_t s;
    s.clear    = clr;
    s.angle[0] = IN_ANGLE_W'(a);
    s.angle[1] = IN_ANGLE_W'(b);
    s.angle[2] = IN_ANGLE_W'(c);
    s.angle[3] = IN_ANGLE_W'(d);
    s.healthy  = ok_mask;
    scan_backlog.push_back(s);
  endtask

  // A reading scattered around a center by up to amp either way, wrapping
  // across zero the way a real shaft angle does.
  function automatic logic [IN_ANGLE_W-1:0] jittered(input int center, input int amp);
    int offs;
    offs = int'($urandom_range(2 * amp)) - amp;
    return IN_ANGLE_W'((center + offs) & ANGLE_TOP);
  endfunction

  // Idle profile in force for the current stretch of accepted scans.
  function automatic int sender_idle_pct();
    if (scans_sent < PROFILE_LEN) return IDLE_LOW_PCT;
    if (scans_sent < 2 * PROFILE_LEN) return IDLE_HIGH_PCT;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (scans_sent < PROFILE_LEN) return IDLE_HIGH_PCT;
    if (scans_sent < 2 * PROFILE_LEN) return IDLE_LOW_PCT;
    return 0;
  endfunction

  // Prints one line per mismatch up to a cap, and counts all of them.
  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("MISMATCH @%0t: %s", $time, what);
    end
  endtask

  // ---------------------------------------------------------------------
  // Clock.
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Input driver. A transfer happens at an edge where in_valid is high and
  // in_stall is low; that scan goes through the window model right there.
  // A new scan is only put up when the previous one has gone or none was
  // up, so a stalled payload never moves, and in_valid is never withdrawn
  // because of in_stall.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : scan_driver
    bit slot_free;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      slot_free = !in_valid;
      if (in_valid && !in_stall) begin
        jitter_due.push_back(advance_window(offered_scan));
        scans_sent <= scans_sent + 1;
        slot_free = 1'b1;
      end
      if (slot_free) begin
        if (scan_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          offered_scan    = scan_backlog.pop_front();
          in_clear_counts <= offered_scan.clear;
          in_angle_a      <= offered_scan.angle[0];
          in_healthy_a    <= offered_scan.healthy[0];
          in_angle_b      <= offered_scan.angle[1];
          in_healthy_b    <= offered_scan.healthy[1];
          in_angle_c      <= offered_scan.angle[2];
          in_healthy_c    <= offered_scan.healthy[2];
          in_angle_d      <= offered_scan.angle[3];
          in_healthy_d    <= offered_scan.healthy[3];
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Long output hold-off. Once, deep into the run, the receiver refuses
  // results for a long stretch while the driver keeps offering scans, so
  // the output register fills and the block has to stall its input.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && scans_sent >= HOLD_START) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------
  // Output monitor. Every result transfer is checked field by field
  // against the oldest result still owed; out_stall is rerolled each edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    jitter_t got;
    jitter_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.noise[0] = out_noise_a;
        got.count[0] = out_count_a;
        got.noise[1] = out_noise_b;
        got.count[1] = out_count_b;
        got.noise[2] = out_noise_c;
        got.count[2] = out_count_c;
        got.noise[3] = out_noise_d;
        got.count[3] = out_count_d;
        if (jitter_due.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with no scan pending", results_seen));
        end else begin
          want = jitter_due.pop_front();
          for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
            if (got.noise[ch] !== want.noise[ch]) begin
              flag_mismatch($sformatf("result %0d noise_%s = %0d, predicted %0d",
                                      results_seen, lane_tag[ch], got.noise[ch],
                                      want.noise[ch]));
            end
            if (got.count[ch] !== want.count[ch]) begin
              flag_mismatch($sformatf("result %0d count_%s = %0d, predicted %0d",
                                      results_seen, lane_tag[ch], got.count[ch],
                                      want.count[ch]));
            end
          end
          for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
            if (want.count[ch] == COUNT_W'(WINDOW_DEPTH)) begin
              full_windows++;
              break;
            end
          end
        end
        results_seen++;
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < receiver_idle_pct());
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int          center [MAX_CHANNELS];
    int          amp [MAX_CHANNELS];
    scan_t       s;

    // Directed scans: angle extremes and alternating bit patterns, the
    // half-turn gap in both directions, gaps that wrap across zero, each
    // channel unhealthy on its own and all together, and clearing the
    // counts both with healthy and with unhealthy readings.
    push_scan(0, 0, 0, 0, 0, 4'b1111);
    push_scan(0, 4095, 2048, 1, 2730, 4'b1111);
    push_scan(0, 2048, 0, 4095, 1365, 4'b1111);
    push_scan(0, 2047, 2049, 2048, 0, 4'b1111);
    push_scan(0, 1365, 2730, 0, 4095, 4'b1111);
    push_scan(0, 0, 0, 0, 0, 4'b1110);
    push_scan(0, 4095, 4095, 4095, 4095, 4'b1101);
    push_scan(0, 2730, 1365, 2730, 1365, 4'b1011);
    push_scan(0, 100, 200, 300, 400, 4'b0111);
    push_scan(0, 4095, 0, 2048, 2047, 4'b0000);
    push_scan(0, 10, 4086, 2058, 2038, 4'b1111);
    push_scan(0, 4090, 6, 2038, 2058, 4'b1111);
    push_scan(1, 3000, 1000, 500, 3500, 4'b1111);
    push_scan(0, 3001, 999, 2548, 1452, 4'b1111);
    push_scan(1, 0, 0, 0, 0, 4'b0000);
    push_scan(1, 4095, 4095, 0, 0, 4'b1010);
    push_scan(0, 2048, 2048, 2048, 2048, 4'b1111);
    push_scan(0, 0, 4095, 1, 2047, 4'b1111);

    // Random scans. Most are long healthy runs of a slowly drifting shaft
    // with a per-segment jitter amplitude, so windows fill to saturation and
    // wrap the ring many times; the rest are raw noise with random health.
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      center[ch] = 0;
      amp[ch]    = 0;
    end
    for (int n = 0; n < RANDOM_SCANS; n++) begin
      if (n % 60 == 0) begin
        for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
          center[ch] = $urandom_range(ANGLE_TOP);
          case ($urandom_range(4))
            0: amp[ch] = 0;
            1: amp[ch] = 2;
            2: amp[ch] = 30;
            3: amp[ch] = 300;
            default: amp[ch] = 2048;
          endcase
        end
      end
      if ($urandom_range(99) < 85) begin
        s.clear = ($urandom_range(99) < 2);
        for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
          if ($urandom_range(99) < 4) begin
            center[ch] = $urandom_range(ANGLE_TOP);
          end else begin
            center[ch] = (center[ch] + int'($urandom_range(2)) - 1) & ANGLE_TOP;
          end
          s.angle[ch]   = jittered(center[ch], amp[ch]);
          s.healthy[ch] = ($urandom_range(99) >= 3);
        end
      end else begin
        s.clear = ($urandom_range(9) == 0);
        for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
          s.angle[ch]   = IN_ANGLE_W'($urandom_range(ANGLE_TOP));
          s.healthy[ch] = 1'($urandom_range(1));
        end
      end
      scan_backlog.push_back(s);
    end
    total_scans = scan_backlog.size();

    // Reset once, synchronously, then let the driver and monitor run.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (scans_sent != total_scans || jitter_due.size() != 0) @(posedge clk);
    // Give the block a full scan time to show any stray extra result.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (jitter_due.size() != 0) begin
      flag_mismatch($sformatf("%0d predicted results never arrived", jitter_due.size()));
    end

    $display("Checked %0d scan results under three idle profiles and one %0d-cycle hold-off.",
             results_seen, HOLD_CYCLES);
    $display("%0d results carried a saturated %0d-sample window; %0d mismatches.",
             full_windows, WINDOW_DEPTH, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Timed out with %0d of %0d scans transferred.", scans_sent, total_scans);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
src/ajwm_pkg.sv
src/ajwm_lane.sv
src/ajwm_seq.sv
src/angle_jitter_window_monitor.sv
bench/tb.sv
